FILE: hw/rtl/pressure_altitude_airspeed_ratio_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pressure altitude and airspeed ratio block
// Immediate-consequence and next-cycle property wrappers, compiled out for
// synthesis builds.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_ALTITUDE_AIRSPEED_RATIO_DEFINES_SVH
`define PRESSURE_ALTITUDE_AIRSPEED_RATIO_DEFINES_SVH

`ifndef SYNTH
`define PAAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("paar assertion failed");
`define PAAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("paar assertion failed");
`else
`define PAAR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PAAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/paar_pkg.sv
// ---------------------------------------------------------------------------
// paar_pkg
// Types, constants and constant tables of the pressure altitude block.
// ---------------------------------------------------------------------------
package paar_pkg;

   typedef struct packed {
      logic [16:0] pressure;
      logic        fresh;
   } req_type;

   typedef struct packed {
      logic signed [21:0] altitude_cm;
      logic               altitude_ok;
      logic [19:0]        airspeed_ratio;
   } rsp_type;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // register indexes
   localparam logic [1:0] CSR_GROUND_PRESSURE = 2'd0;
   localparam logic [1:0] CSR_GROUND_TEMP     = 2'd1;
   localparam logic [1:0] CSR_ALTITUDE_OFFSET = 2'd2;

   localparam logic signed [21:0] ALT_MIN   = -22'sd2097152;
   localparam logic signed [21:0] ALT_MAX   = 22'sd2097151;
   localparam logic [19:0]        RATIO_MAX = 20'hFFFFF;
   localparam logic [22:0]        RECOMPUTE_CM = 23'd10000;

   localparam int EXPO_Q20   = 199501;
   localparam int HEIGHT_Q16 = 10082465;
   localparam int LAPSE_Q24  = 109052;
   localparam int AIR_Q16    = 230617;
   localparam int KELVIN_CC  = 27315;

   localparam logic [5:0] LOG_LAST  = 6'd15;
   localparam logic [5:0] EXP_LAST  = 6'd15;
   localparam logic [5:0] DIV_LAST  = 6'd51;
   localparam logic [5:0] SQRT_LAST = 6'd25;

   typedef logic [31:0] root_tab_type [16];

   function automatic logic [63:0] isqrt_c(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bv;
      rem = v;
      res = '0;
      bv  = 64'h1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bv) begin
            rem = rem - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-i) in Q30 for i = 1..16, each the floor root of the one before
   function automatic root_tab_type exp_roots();
      root_tab_type r;
      logic [63:0]  a;
      a = 64'h1 << 31;
      for (int i = 0; i < 16; i++) begin
         a    = isqrt_c(a << 30);
         r[i] = a[31:0];
      end
      return r;
   endfunction

   localparam root_tab_type EXP_ROOT = exp_roots();

endpackage

FILE: hw/rtl/paar_mul.sv
// ---------------------------------------------------------------------------
// paar_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module paar_mul (
   input  logic                                clock,
   input  logic signed [paar_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [paar_pkg::MUL_W-1:0]   mul_b,
   output logic signed [paar_pkg::PROD_W-1:0]  prod_ff
);
   import paar_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: hw/rtl/pressure_altitude_airspeed_ratio.sv
// ---------------------------------------------------------------------------
// pressure_altitude_airspeed_ratio
// Barometric altitude and equivalent-to-true airspeed ratio from a pressure
// sample, in fixed point, on one shared multiplier under a sequencer.
// ---------------------------------------------------------------------------
//
//   channel  ports                         direction  beat
//   req      req_valid/req_stall/req_data  in         pressure, fresh
//   rsp      rsp_valid/rsp_stall/rsp_data  out        altitude, ok, ratio
//   csr      csr_valid/csr_ready/index     in         register write
//
// One request beat at a time. A fresh calibrated sample with a ratio
// recompute runs two 16-round log2 squarings, 16 exp2 rounds, a 52-step
// divide and a 26-step square root before its result is loaded; one that
// reruns neither altitude nor ratio passes straight to the output state.
// Reset is synchronous and clears the configuration and held state.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result loads once the output beat is gone.
// Requests are stalled while a register write is offered.
// ---------------------------------------------------------------------------
`include "pressure_altitude_airspeed_ratio_defines.svh"

module pressure_altitude_airspeed_ratio (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  paar_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output paar_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [16:0]       csr_wdata
);
   import paar_pkg::*;

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_LSQ  = 5'd1;   // square log mantissa
   localparam logic [4:0] S_LUP  = 5'd2;   // take log bit
   localparam logic [4:0] S_EMUL = 5'd3;   // log ratio times exponent
   localparam logic [4:0] S_ESET = 5'd4;
   localparam logic [4:0] S_XMUL = 5'd5;   // exp2 factor multiply
   localparam logic [4:0] S_XUP  = 5'd6;
   localparam logic [4:0] S_TMUL = 5'd7;   // height scale times temperature
   localparam logic [4:0] S_TSET = 5'd8;
   localparam logic [4:0] S_VMUL = 5'd9;   // scale times (1 - y)
   localparam logic [4:0] S_ALT  = 5'd10;
   localparam logic [4:0] S_RCHK = 5'd11;  // ratio cache check
   localparam logic [4:0] S_TK   = 5'd12;
   localparam logic [4:0] S_NLO  = 5'd13;
   localparam logic [4:0] S_NHI  = 5'd14;
   localparam logic [4:0] S_NSUM = 5'd15;
   localparam logic [4:0] S_DIV  = 5'd16;
   localparam logic [4:0] S_SQRT = 5'd17;
   localparam logic [4:0] S_OUT  = 5'd18;

   // control and held state
   logic [4:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        gp_ff, gp_in;
   logic signed [14:0] gt_ff, gt_in;
   logic signed [7:0]  off_ff, off_in;
   logic signed [21:0] held_ff, held_in;
   logic               valid_ff, valid_in;
   logic [19:0]        cached_ff, cached_in;
   logic signed [21:0] ralt_ff, ralt_in;

   // working registers
   logic [16:0]        p_ff, p_in;
   logic               lsel_ff, lsel_in;
   logic               zero_ff, zero_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [20:0]        lp_ff, lp_in;
   logic signed [21:0] d_ff, d_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [15:0]        ef_ff, ef_in;
   logic signed [5:0]  n_ff, n_in;
   logic [30:0]        t_ff, t_in;
   logic signed [26:0] v_ff, v_in;
   logic signed [41:0] tk_ff, tk_in;
   logic [37:0]        acc_ff, acc_in;
   logic [51:0]        dq_ff, dq_in;
   logic [16:0]        rem_ff, rem_in;
   logic [51:0]        res_ff, res_in;
   logic [51:0]        bit_ff, bit_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   // datapath terms
   logic signed [16:0] tc;
   logic [16:0]        lsrc;
   logic [4:0]         le;
   logic [31:0]        sq;
   logic [15:0]        frac_nx;
   logic [30:0]        m_sq_nx;
   logic [20:0]        lg_nx;
   logic [21:0]        e_val;
   logic [4:0]         sh_pos;
   logic [5:0]         sh_neg;
   logic [51:0]        y_val;
   logic signed [52:0] v_full;
   logic signed [52:0] v_sh;
   logic signed [PROD_W-1:0] alt_sum;
   logic [37:0]        alt_w;
   logic               alt_fits;
   logic signed [22:0] diff;
   logic [22:0]        abs_diff;
   logic signed [41:0] tk_calc;
   logic               tk_pos;
   logic [59:0]        num;
   logic [17:0]        div_t;
   logic [17:0]        div_sub;
   logic               div_ge;
   logic [51:0]        sq_rb;
   logic               sq_ge;
   logic [51:0]        res_nx;
   logic signed [15:0] off_cm;
   logic signed [23:0] alt_out_w;
   logic signed [21:0] alt_out;
   logic               req_take;
   logic               slot_free;

   function automatic logic [4:0] msb_pos(input logic [16:0] x);
      logic [4:0] pos;
      pos = '0;
      for (int i = 1; i < 17; i++) begin
         if (x[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

   // align the leading one to bit 30
   function automatic logic [30:0] norm_q30(input logic [16:0] x);
      logic [4:0] pos;
      pos = msb_pos(x);
      return {14'b0, x} << (5'd30 - pos);
   endfunction

   paar_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // hold requests off while busy or while a register write is offered
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ground temperature in centikelvin, always positive
   assign tc = $signed({{2{gt_ff[14]}}, gt_ff}) + 17'sd27315;

   // log2 round: square the mantissa, take one fraction bit
   assign lsrc    = lsel_ff ? gp_ff : p_ff;
   assign le      = msb_pos(lsrc);
   assign sq      = prod_ff[61:30];
   assign frac_nx = {frac_ff[14:0], sq[31]};
   assign m_sq_nx = sq[31] ? sq[31:1] : sq[30:0];
   assign lg_nx   = {le, frac_nx};

   // exponent product, floor shift by 20
   assign e_val = prod_ff[41:20];

   // scale the exp2 mantissa by the integer part of the exponent
   always_comb begin
      sh_pos = (n_ff > 6'sd20) ? 5'd20 : n_ff[4:0];
      sh_neg = 6'(-n_ff);
      if (zero_ff) begin
         y_val = '0;
      end else if (!n_ff[5]) begin
         y_val = {21'b0, m_ff} << sh_pos;
      end else begin
         y_val = {21'b0, m_ff} >> sh_neg;
      end
   end

   assign v_full = $signed(53'h1 << 30) - $signed({1'b0, y_val});
   assign v_sh   = v_full >>> 10;

   // round and range check the altitude
   assign alt_sum  = prod_ff + $signed(PROD_W'(134217728));
   assign alt_w    = alt_sum[65:28];
   assign alt_fits = (&alt_w[37:21]) || !(|alt_w[37:21]);

   assign diff     = $signed({held_ff[21], held_ff}) - $signed({ralt_ff[21], ralt_ff});
   assign abs_diff = diff[22] ? 23'(-diff) : 23'(diff);

   // temperature at the held altitude in centikelvin Q24
   assign tk_calc = $signed({tc[16], tc, 24'b0}) - $signed(prod_ff[41:0]);
   assign tk_pos  = !tk_calc[41] && (tk_calc != '0);

   assign num = {prod_ff[39:0], 20'b0} + {22'b0, acc_ff};

   // restoring divide, one quotient bit a cycle
   assign div_t   = {rem_ff, dq_ff[51]};
   assign div_sub = div_t - {1'b0, p_ff};
   assign div_ge  = (div_t >= {1'b0, p_ff});

   // digit-by-digit square root, one result bit a cycle
   assign sq_rb  = res_ff + bit_ff;
   assign sq_ge  = (dq_ff >= sq_rb);
   assign res_nx = sq_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // reported altitude: held value plus offset, saturated, zero if uncalibrated
   assign off_cm    = $signed({{8{off_ff[7]}}, off_ff}) * 16'sd100;
   assign alt_out_w = $signed({{2{held_ff[21]}}, held_ff}) + $signed({{8{off_cm[15]}}, off_cm});
   always_comb begin
      if (gp_ff == '0) begin
         alt_out = '0;
      end else if (alt_out_w < $signed({{2{ALT_MIN[21]}}, ALT_MIN})) begin
         alt_out = ALT_MIN;
      end else if (alt_out_w > $signed({{2{ALT_MAX[21]}}, ALT_MAX})) begin
         alt_out = ALT_MAX;
      end else begin
         alt_out = alt_out_w[21:0];
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LSQ: begin
            mul_a = {2'b0, m_ff};
            mul_b = {2'b0, m_ff};
         end
         S_EMUL: begin
            mul_a = {{11{d_ff[21]}}, d_ff};
            mul_b = MUL_W'(EXPO_Q20);
         end
         S_XMUL: begin
            mul_a = {2'b0, m_ff};
            mul_b = {1'b0, EXP_ROOT[cnt_ff[3:0]]};
         end
         S_TMUL: begin
            mul_a = MUL_W'(HEIGHT_Q16);
            mul_b = {{16{tc[16]}}, tc};
         end
         S_VMUL: begin
            mul_a = {2'b0, t_ff};
            mul_b = {{6{v_ff[26]}}, v_ff};
         end
         S_RCHK: begin
            mul_a = MUL_W'(LAPSE_Q24);
            mul_b = {{11{held_ff[21]}}, held_ff};
         end
         S_NLO: begin
            mul_a = {13'b0, tk_ff[19:0]};
            mul_b = MUL_W'(AIR_Q16);
         end
         S_NHI: begin
            mul_a = {12'b0, tk_ff[40:20]};
            mul_b = MUL_W'(AIR_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      gp_in        = gp_ff;
      gt_in        = gt_ff;
      off_in       = off_ff;
      held_in      = held_ff;
      valid_in     = valid_ff;
      cached_in    = cached_ff;
      ralt_in      = ralt_ff;
      p_in         = p_ff;
      lsel_in      = lsel_ff;
      zero_in      = zero_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      lp_in        = lp_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      ef_in        = ef_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      tk_in        = tk_ff;
      acc_in       = acc_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;

      // drop the output beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GROUND_PRESSURE: gp_in  = csr_wdata;
            CSR_GROUND_TEMP:     gt_in  = csr_wdata[14:0];
            CSR_ALTITUDE_OFFSET: off_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               p_in     = req_data.pressure;
               zero_in  = 1'b0;
               lsel_in  = 1'b0;
               cnt_in   = '0;
               m_in     = norm_q30(req_data.pressure);
               if ((gp_ff != '0) && req_data.fresh) begin
                  if (req_data.pressure == '0) begin
                     zero_in  = 1'b1;
                     state_in = S_TMUL;
                  end else begin
                     state_in = S_LSQ;
                  end
               end else begin
                  state_in = S_RCHK;
               end
            end
         end
         S_LSQ: begin
            state_in = S_LUP;
         end
         S_LUP: begin
            frac_in = frac_nx;
            m_in    = m_sq_nx;
            cnt_in  = cnt_ff + 6'd1;
            state_in = S_LSQ;
            if (cnt_ff == LOG_LAST) begin
               cnt_in = '0;
               if (!lsel_ff) begin
                  // sample done, advance to the ground pressure
                  lp_in   = lg_nx;
                  lsel_in = 1'b1;
                  m_in    = norm_q30(gp_ff);
               end else begin
                  d_in     = $signed({1'b0, lp_ff}) - $signed({1'b0, lg_nx});
                  state_in = S_EMUL;
               end
            end
         end
         S_EMUL: begin
            state_in = S_ESET;
         end
         S_ESET: begin
            ef_in    = e_val[15:0];
            n_in     = e_val[21:16];
            m_in     = 31'h4000_0000;
            cnt_in   = '0;
            state_in = S_XMUL;
         end
         S_XMUL: begin
            state_in = S_XUP;
         end
         S_XUP: begin
            if (ef_ff[4'd15 - cnt_ff[3:0]]) begin
               m_in = prod_ff[60:30];
            end
            cnt_in   = cnt_ff + 6'd1;
            state_in = (cnt_ff == EXP_LAST) ? S_TMUL : S_XMUL;
         end
         S_TMUL: begin
            state_in = S_TSET;
         end
         S_TSET: begin
            t_in     = prod_ff[38:8];
            v_in     = v_sh[26:0];
            state_in = S_VMUL;
         end
         S_VMUL: begin
            state_in = S_ALT;
         end
         S_ALT: begin
            if (alt_fits) begin
               held_in  = alt_w[21:0];
               valid_in = 1'b1;
            end else begin
               valid_in = 1'b0;
            end
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if ((abs_diff < RECOMPUTE_CM) && (cached_ff != '0)) begin
               state_in = S_OUT;
            end else begin
               ralt_in  = held_ff;
               state_in = S_TK;
            end
         end
         S_TK: begin
            tk_in = tk_calc;
            if (!tk_pos) begin
               cached_in = '0;
               state_in  = S_OUT;
            end else if (p_ff == '0) begin
               cached_in = RATIO_MAX;
               state_in  = S_OUT;
            end else begin
               state_in = S_NLO;
            end
         end
         S_NLO: begin
            state_in = S_NHI;
         end
         S_NHI: begin
            acc_in   = prod_ff[37:0];
            state_in = S_NSUM;
         end
         S_NSUM: begin
            // dividing by pressure after dropping 8 bits equals dividing by pressure * 256
            dq_in    = num[59:8];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? div_sub[16:0] : div_t[16:0];
            dq_in  = {dq_ff[50:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               res_in   = '0;
               bit_in   = 52'h1 << 50;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_ge) begin
               dq_in = dq_ff - sq_rb;
            end
            res_in = res_nx;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               cached_in = (res_nx > {32'b0, RATIO_MAX}) ? RATIO_MAX : res_nx[19:0];
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_in.altitude_cm    = alt_out;
               rsp_in.altitude_ok    = valid_ff;
               rsp_in.airspeed_ratio = cached_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         gp_ff        <= '0;
         gt_ff        <= '0;
         off_ff       <= '0;
         held_ff      <= '0;
         valid_ff     <= 1'b0;
         cached_ff    <= '0;
         ralt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gp_ff        <= gp_in;
         gt_ff        <= gt_in;
         off_ff       <= off_in;
         held_ff      <= held_in;
         valid_ff     <= valid_in;
         cached_ff    <= cached_in;
         ralt_ff      <= ralt_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      lsel_ff  <= lsel_in;
      zero_ff  <= zero_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      lp_ff    <= lp_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      ef_ff    <= ef_in;
      n_ff     <= n_in;
      t_ff     <= t_in;
      v_ff     <= v_in;
      tk_ff    <= tk_in;
      acc_ff   <= acc_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      rsp_ff   <= rsp_in;
   end

   // the log mantissa stays normalized while squaring
   `PAAR_ASSERT_IMPL(a_log_norm, clock, reset, state_ff == S_LSQ, m_ff[30])
   // the divide remainder stays below the divisor
   `PAAR_ASSERT_IMPL(a_div_rem, clock, reset, state_ff == S_DIV, rem_ff < p_ff)
   // an accepted request always starts work
   `PAAR_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != S_IDLE)

endmodule

FILE: tb/paar_scoreboard.sv
// ---------------------------------------------------------------------------
// paar_scoreboard
// Watches the request, result and register channels of the pressure altitude
// block. Predicts every result beat and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module paar_scoreboard
   import paar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output int          mismatch_count,
   output int          waiting_count,
   output int          result_count
);

   // register copies
   logic [16:0]        gnd_pressure;
   logic signed [14:0] gnd_temp;
   logic signed [7:0]  offset_m;

   // held altitude and cached ratio
   logic signed [21:0] held_alt;
   logic               held_ok;
   logic [19:0]        ratio_cache;
   logic signed [21:0] ratio_alt;

   rsp_type expected_beats[$];

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bv;
      rem  = v;
      root = '0;
      bv   = 64'h1 << 62;
      while (bv != 0) begin
         if (rem >= root + bv) begin
            rem  = rem - (root + bv);
            root = (root >> 1) + bv;
         end else begin
            root = root >> 1;
         end
         bv = bv >> 2;
      end
      return root;
   endfunction

   // log2 in Q16 by repeated squaring of a Q30 mantissa
   function automatic longint log2_fix(input logic [16:0] x);
      int          e;
      logic [63:0] m;
      logic [15:0] frac;
      e = 0;
      while (e < 16 && (x >> (e + 1)) != 0)
         e++;
      m    = 64'(x) << (30 - e);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m    = (m * m) >> 30;
         frac = {frac[14:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            m       = m >> 1;
         end
      end
      return (longint'(e) << 16) | longint'(frac);
   endfunction

   // 2^ex, ex in Q16, result in Q30
   function automatic logic [63:0] exp2_fix(input longint ex);
      longint      n;
      logic [15:0] f;
      logic [63:0] m;
      logic [63:0] a;
      n = ex >>> 16;
      f = ex[15:0];
      m = 64'h1 << 30;
      a = 64'h1 << 31;
      for (int i = 1; i <= 16; i++) begin
         a = int_root(a << 30);
         if (f[16-i])
            m = (m * a) >> 30;
      end
      if (n >= 0) begin
         if (n > 20)
            n = 20;
         return m << n;
      end
      if (n < -62)
         return '0;
      return m >> (-n);
   endfunction

   function automatic longint altitude_of(input logic [16:0] p);
      longint      tc;
      longint      d;
      longint      v;
      longint      t;
      logic [63:0] y;
      tc = longint'(gnd_temp) + KELVIN_CC;
      y  = '0;
      if (p != 0) begin
         d = log2_fix(p) - log2_fix(gnd_pressure);
         y = exp2_fix((d * EXPO_Q20) >>> 20);
      end
      v = ((64'sd1 <<< 30) - longint'(y)) >>> 10;
      t = (longint'(HEIGHT_Q16) * tc) >>> 8;
      return (t * v + (64'sd1 <<< 27)) >>> 28;
   endfunction

   function automatic logic [19:0] ratio_of(input logic [16:0] p);
      longint      tk;
      logic [63:0] r2;
      logic [63:0] r;
      tk = (longint'(gnd_temp) + KELVIN_CC) * (64'sd1 <<< 24)
           - longint'(LAPSE_Q24) * longint'(held_alt);
      if (tk <= 0)
         return '0;
      if (p == 0)
         return RATIO_MAX;
      r2 = (64'(tk) * 64'(AIR_Q16)) / (64'(p) << 8);
      r  = int_root(r2);
      return (r > 64'(RATIO_MAX)) ? RATIO_MAX : r[19:0];
   endfunction

   assign waiting_count = expected_beats.size();

   always @(posedge clock) begin
      longint  a;
      longint  alt_out;
      longint  diff;
      rsp_type exp_beat;
      rsp_type got;
      if (reset) begin
         gnd_pressure = '0;
         gnd_temp     = '0;
         offset_m     = '0;
         held_alt     = '0;
         held_ok      = 1'b0;
         ratio_cache  = '0;
         ratio_alt    = '0;
         expected_beats.delete();
         mismatch_count = 0;
         result_count   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GROUND_PRESSURE: gnd_pressure = csr_wdata;
               CSR_GROUND_TEMP:     gnd_temp     = csr_wdata[14:0];
               CSR_ALTITUDE_OFFSET: offset_m     = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            alt_out = 0;
            if (gnd_pressure != 0) begin
               if (req_data.fresh) begin
                  a = altitude_of(req_data.pressure);
                  if (a < longint'(ALT_MIN) || a > longint'(ALT_MAX)) begin
                     held_ok = 1'b0;
                  end else begin
                     held_alt = a[21:0];
                     held_ok  = 1'b1;
                  end
               end
               alt_out = longint'(held_alt) + longint'(offset_m) * 100;
               if (alt_out < longint'(ALT_MIN))
                  alt_out = longint'(ALT_MIN);
               if (alt_out > longint'(ALT_MAX))
                  alt_out = longint'(ALT_MAX);
            end
            // refresh the cached ratio after a 100 m move or when it is zero
            diff = longint'(held_alt) - longint'(ratio_alt);
            if (diff < 0)
               diff = -diff;
            if (!(diff < 10000 && ratio_cache != 0)) begin
               ratio_cache = ratio_of(req_data.pressure);
               ratio_alt   = held_alt;
            end
            exp_beat.altitude_cm    = alt_out[21:0];
            exp_beat.altitude_ok    = held_ok;
            exp_beat.airspeed_ratio = ratio_cache;
            expected_beats.push_back(exp_beat);
         end

         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            result_count++;
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: %h", got);
               mismatch_count++;
            end else begin
               exp_beat = expected_beats.pop_front();
               if (got.altitude_cm !== exp_beat.altitude_cm) begin
                  $error("altitude_cm expected %0d actual %0d",
                         exp_beat.altitude_cm, got.altitude_cm);
                  mismatch_count++;
               end
               if (got.altitude_ok !== exp_beat.altitude_ok) begin
                  $error("altitude_ok expected %0d actual %0d",
                         exp_beat.altitude_ok, got.altitude_ok);
                  mismatch_count++;
               end
               if (got.airspeed_ratio !== exp_beat.airspeed_ratio) begin
                  $error("airspeed_ratio expected %0d actual %0d",
                         exp_beat.airspeed_ratio, got.airspeed_ratio);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_pressure_altitude_airspeed_ratio.sv
// ---------------------------------------------------------------------------
// tb_pressure_altitude_airspeed_ratio
// Drives pressure samples and register writes into the altitude block under
// random idling on both channels; the scoreboard beside it predicts and checks.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pressure_altitude_airspeed_ratio;
   import paar_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 250;   // beyond the worst-case latency
   localparam int PER_PHASE   = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_GROUND_PRESSURE;
   logic [16:0] csr_wdata = '0;

   int mismatch_count;
   int waiting_count;
   int result_count;
   int cycles = 0;
   int beats_sent = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;

   // phase settings: ground pressure, ground temperature, offset
   logic [16:0]        set_gp  [6] = '{101325, 0, 1, 131071, 80000, 101325};
   logic signed [14:0] set_gt  [6] = '{1500, 2000, -4000, 8500, -16384, 16383};
   logic signed [7:0]  set_off [6] = '{0, 5, -128, 127, -37, 64};

   pressure_altitude_airspeed_ratio dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   paar_scoreboard scoreboard (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .mismatch_count, .waiting_count, .result_count
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // give up on a hung block
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result back-pressure, redrawn each falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // hold one beat on the request channel until it is taken; valid stays
   // high into the next beat unless an idle gap is drawn
   task automatic send_beat(input logic [16:0] p, input logic f);
      bit taken;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data      <= '{pressure: p, fresh: f};
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
      bit done;
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = csr_ready;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait out every expected result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (waiting_count != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_regs(input logic [16:0] gp, input logic signed [14:0] gt,
                           input logic signed [7:0] off);
      write_reg(CSR_GROUND_PRESSURE, gp);
      write_reg(CSR_GROUND_TEMP, {2'b00, gt});
      write_reg(CSR_ALTITUDE_OFFSET, {9'd0, off});
   endtask

   // mostly pressures near ground level, with full-range and edge noise
   task automatic random_beat(input logic [16:0] gp);
      int          mode;
      int          pv;
      logic [16:0] p;
      mode = $urandom_range(99);
      if (mode < 70 && gp != 0) begin
         pv = int'(gp) - int'($urandom_range(gp / 2)) + int'($urandom_range(gp / 10));
         if (pv > 131071)
            pv = 131071;
         p = pv[16:0];
      end else if (mode < 88) begin
         p = $urandom_range(131071);
      end else if (mode < 93) begin
         p = '0;
      end else if (mode < 97) begin
         p = 17'h1FFFF;
      end else begin
         p = $urandom_range(16);
      end
      send_beat(p, $urandom_range(99) < 85);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // uncalibrated: altitude reads zero, ratio still produced
      send_beat(17'd101325, 1'b1);
      send_beat(17'd0, 1'b1);
      send_beat(17'd50000, 1'b0);
      drain();

      // directed: extremes, stale samples, zero pressure, overflow
      set_regs(17'd101325, 15'sd1500, 8'sd0);
      send_beat(17'd101325, 1'b1);
      send_beat(17'd101325, 1'b0);
      send_beat(17'd90000, 1'b1);
      send_beat(17'd70000, 1'b1);
      send_beat(17'd131071, 1'b1);
      send_beat(17'd1, 1'b1);
      send_beat(17'd0, 1'b1);       // out of range altitude, held value kept
      send_beat(17'd0, 1'b0);
      send_beat(17'd30000, 1'b1);
      send_beat(17'd20000, 1'b1);
      send_beat(17'd100000, 1'b0);
      send_beat(17'd65536, 1'b1);
      drain();
      // very cold ground and a high altitude drive the temperature below zero
      set_regs(17'd131071, -15'sd16384, -8'sd128);
      send_beat(17'd1000, 1'b1);
      send_beat(17'd200, 1'b1);
      send_beat(17'd200, 1'b0);
      send_beat(17'd131071, 1'b1);
      send_beat(17'd65535, 1'b1);
      send_beat(17'd0, 1'b1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_gap_pct = 32;
            stall_pct    = 47;
         end else if (ph < 4) begin
            send_gap_pct = 47;
            stall_pct    = 32;
         end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         set_regs(set_gp[ph], set_gt[ph], set_off[ph]);
         for (int k = 0; k < PER_PHASE; k++)
            random_beat(set_gp[ph]);
         drain();
      end

      $display("Sent %0d pressure beats over 8 register settings and 3 idling modes,",
               beats_sent);
      $display("checked %0d result beats.", result_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/paar_pkg.sv
hw/rtl/paar_mul.sv
hw/rtl/pressure_altitude_airspeed_ratio.sv
tb/paar_scoreboard.sv
tb/tb_pressure_altitude_airspeed_ratio.sv
